// File: hdl/sorted_priority_queue_defines.svh
// ----------------------------------------------------------------------------
// Sorted priority queue: assertion macros
// Shared macros for the concurrent checks on the queue's ports.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted priority queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted priority queue check failed");

`endif

// File: hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Types, codes and constants shared by the queue's modules.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int DATA_W        = 32;
    localparam int COUNT_W       = 4;
    localparam int MAX_OUT       = 8;
    localparam int IDX_W         = $clog2(MAX_OUT);
    localparam int DUMP_N_W      = $clog2(MAX_OUT + 1);

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_DUMP   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_EMPTY    = 2'd2;
    localparam logic [1:0] STATUS_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]               mode;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] data;
        logic                     last;
        logic [COUNT_W-1:0]       count;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DUMP
    } state_t;

    typedef struct packed {
        logic             load;
        logic             exec;
        logic             dump;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       empty;
        logic       dump_last;
    } dp_status_t;

endpackage

// File: hdl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// Sorted priority queue
// Keeps signed values in ascending order with insert, delete and dump.
// ----------------------------------------------------------------------------
//  Channel   Ports              Handshake
//  request   start, req         taken when start is high and busy is low
//  result    strobe, rsp        valid for one cycle while strobe is high
//
// An insert or delete holds busy in the execute state, and its result
// appears on the following cycle, when a new request can already be
// taken. A dump stays busy through the execute state and the entries it
// shows, at most eight, one at a time through the single read port.
// Reset clears the occupancy; the stored entries stay undefined until written.
// The receiver cannot stall the result port.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  spq_pkg::req_t req,
    output logic          strobe,
    output spq_pkg::rsp_t rsp
);

    spq_pkg::cmd_t       cmd;
    spq_pkg::dp_status_t status;

    spq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .start_mode (req.mode),
        .status     (status),
        .busy       (busy),
        .cmd        (cmd)
    );

    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .status (status),
        .strobe (strobe),
        .rsp    (rsp)
    );

endmodule

// File: hdl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted priority queue controller
// Sequences request capture, execution and the entry-by-entry dump.
// ----------------------------------------------------------------------------
module spq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          start_mode,
    input  spq_pkg::dp_status_t status,
    output logic                busy,
    output spq_pkg::cmd_t       cmd
);

    spq_pkg::state_t                 state_reg;
    spq_pkg::state_t                 state_next;
    logic [spq_pkg::IDX_W-1:0]       idx_reg;
    logic [spq_pkg::IDX_W-1:0]       idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spq_pkg::ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                if (start && (start_mode != spq_pkg::MODE_UNUSED))
                begin
                    state_next = spq_pkg::ST_EXEC;
                end
            end
            spq_pkg::ST_EXEC:
            begin
                if ((status.mode == spq_pkg::MODE_DUMP) && !status.empty)
                begin
                    state_next = spq_pkg::ST_DUMP;
                    idx_next   = '0;
                end
                else
                begin
                    state_next = spq_pkg::ST_IDLE;
                end
            end
            spq_pkg::ST_DUMP:
            begin
                if (status.dump_last)
                begin
                    state_next = spq_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + spq_pkg::IDX_W'(1);
                end
            end
            default:
            begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy     = (state_reg != spq_pkg::ST_IDLE);
        cmd.load = (state_reg == spq_pkg::ST_IDLE) && start;
        cmd.exec = (state_reg == spq_pkg::ST_EXEC);
        cmd.dump = (state_reg == spq_pkg::ST_DUMP);
        cmd.idx  = idx_reg;
    end

endmodule

// File: hdl/spq_datapath.sv
// ----------------------------------------------------------------------------
// Sorted priority queue datapath
// Chain of compare-and-shift cells, occupancy and the result register.
// ----------------------------------------------------------------------------
module spq_datapath #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  spq_pkg::req_t       req,
    input  spq_pkg::cmd_t       cmd,
    output spq_pkg::dp_status_t status,
    output logic                strobe,
    output spq_pkg::rsp_t       rsp
);

    localparam int OCC_W = $clog2(DEPTH + 1);

    spq_pkg::req_t                      req_reg;
    logic [OCC_W-1:0]                   occ_reg;
    logic [OCC_W-1:0]                   occ_next;
    logic signed [spq_pkg::DATA_W-1:0]  cell_reg  [DEPTH];
    logic signed [spq_pkg::DATA_W-1:0]  cell_next [DEPTH];
    logic signed [spq_pkg::DATA_W-1:0]  ins_cell  [DEPTH];
    logic signed [spq_pkg::DATA_W-1:0]  del_cell  [DEPTH];
    logic signed [spq_pkg::DATA_W-1:0]  view      [spq_pkg::MAX_OUT];
    logic                               strobe_reg;
    logic                               strobe_next;
    spq_pkg::rsp_t                      rsp_reg;
    spq_pkg::rsp_t                      rsp_next;

    logic signed [spq_pkg::DATA_W-1:0]  value_s;
    logic [DEPTH-1:0]                   in_use;
    logic [DEPTH-1:0]                   gt;
    logic [DEPTH-1:0]                   eq;
    logic [DEPTH-1:0]                   ge;
    logic                               found;
    logic                               full;
    logic                               empty;
    logic [spq_pkg::DUMP_N_W-1:0]       dump_n;
    logic                               dump_last;
    logic                               do_insert;
    logic                               do_delete;

    assign value_s = $signed(req_reg.value);

    // Each cell compares its own entry with the request value. Because the
    // entries are sorted, the insert and delete positions follow directly.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign in_use[i] = (occ_reg > OCC_W'(i));
        assign gt[i]     = !in_use[i] || (value_s < cell_reg[i]);
        assign eq[i]     = in_use[i] && (cell_reg[i] == value_s);
        assign ge[i]     = !in_use[i] || (cell_reg[i] >= value_s);
        if (i == 0)
        begin : g_first
            assign ins_cell[i] = gt[i] ? value_s : cell_reg[i];
        end
        else
        begin : g_rest
            assign ins_cell[i] = !gt[i] ? cell_reg[i] :
                                 (!gt[i-1] ? value_s : cell_reg[i-1]);
        end
        if (i == DEPTH - 1)
        begin : g_top
            assign del_cell[i] = cell_reg[i];
        end
        else
        begin : g_below
            assign del_cell[i] = (found && ge[i]) ? cell_reg[i+1] : cell_reg[i];
        end
    end

    for (genvar k = 0; k < spq_pkg::MAX_OUT; k++)
    begin : g_view
        if (k < DEPTH)
        begin : g_live
            assign view[k] = cell_reg[k];
        end
        else
        begin : g_none
            assign view[k] = '0;
        end
    end

    assign found = |eq;
    assign full  = (occ_reg == OCC_W'(DEPTH));
    assign empty = (occ_reg == '0);

    always_comb
    begin
        if (32'(occ_reg) > spq_pkg::MAX_OUT)
        begin
            dump_n = spq_pkg::DUMP_N_W'(spq_pkg::MAX_OUT);
        end
        else
        begin
            dump_n = spq_pkg::DUMP_N_W'(occ_reg);
        end
        dump_last = ((spq_pkg::DUMP_N_W'(cmd.idx) + spq_pkg::DUMP_N_W'(1)) == dump_n);
    end

    always_comb
    begin
        occ_next        = occ_reg;
        strobe_next     = 1'b0;
        do_insert       = 1'b0;
        do_delete       = 1'b0;
        rsp_next.status = spq_pkg::STATUS_OK;
        rsp_next.data   = '0;
        rsp_next.last   = 1'b1;
        if (cmd.exec)
        begin
            case (req_reg.mode)
                spq_pkg::MODE_INSERT:
                begin
                    strobe_next = 1'b1;
                    if (full)
                    begin
                        rsp_next.status = spq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        do_insert = 1'b1;
                        occ_next  = occ_reg + OCC_W'(1);
                    end
                end
                spq_pkg::MODE_DELETE:
                begin
                    strobe_next = 1'b1;
                    if (empty)
                    begin
                        rsp_next.status = spq_pkg::STATUS_EMPTY;
                    end
                    else if (found)
                    begin
                        do_delete = 1'b1;
                        occ_next  = occ_reg - OCC_W'(1);
                    end
                    else
                    begin
                        rsp_next.status = spq_pkg::STATUS_NOTFOUND;
                    end
                end
                spq_pkg::MODE_DUMP:
                begin
                    if (empty)
                    begin
                        strobe_next     = 1'b1;
                        rsp_next.status = spq_pkg::STATUS_EMPTY;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.dump)
        begin
            strobe_next   = 1'b1;
            rsp_next.data = view[cmd.idx];
            rsp_next.last = dump_last;
        end
        rsp_next.count = spq_pkg::COUNT_W'(occ_next);
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (do_insert)
            begin
                cell_next[i] = ins_cell[i];
            end
            else if (do_delete)
            begin
                cell_next[i] = del_cell[i];
            end
            else
            begin
                cell_next[i] = cell_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
        rsp_reg  <= rsp_next;
        if (cmd.load)
        begin
            req_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            occ_reg    <= occ_next;
            strobe_reg <= strobe_next;
        end
    end

    assign status.mode      = req_reg.mode;
    assign status.empty     = empty;
    assign status.dump_last = dump_last;
    assign strobe           = strobe_reg;
    assign rsp              = rsp_reg;

endmodule

// File: hdl/spq_checker.sv
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Port-level checks on request and result sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_defines.svh"

module spq_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input spq_pkg::req_t req,
    input logic          strobe,
    input spq_pkg::rsp_t rsp
);

    `SPQ_ASSERT_NEXT(a_request_makes_busy, start && !busy && (req.mode != spq_pkg::MODE_UNUSED), busy)
    `SPQ_ASSERT_NEXT(a_dump_continues, strobe && !rsp.last, strobe)
    `SPQ_ASSERT_SAME(a_partial_dump_busy, strobe && !rsp.last, busy)
    `SPQ_ASSERT_SAME(a_failure_is_last, strobe && (rsp.status != spq_pkg::STATUS_OK), rsp.last)
    `SPQ_ASSERT_SAME(a_empty_has_no_count, strobe && (rsp.status == spq_pkg::STATUS_EMPTY), rsp.count == '0)

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Sends insert, delete and dump requests, first directed and then random,
// and checks every result against a predictor of the ordered store.
// ----------------------------------------------------------------------------
module testbench;

    localparam int STORE_DEPTH  = spq_pkg::DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;

    localparam logic signed [spq_pkg::DATA_W-1:0] VALUE_MAX = 32'sh7fffffff;
    localparam logic signed [spq_pkg::DATA_W-1:0] VALUE_MIN = 32'sh80000000;

    logic          clk   = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    spq_pkg::req_t req   = '0;
    logic          strobe;
    spq_pkg::rsp_t rsp;

    logic signed [spq_pkg::DATA_W-1:0] queue_entries [STORE_DEPTH];
    int            queue_fill      = 0;
    spq_pkg::rsp_t expected_rsp [$];
    int            error_count     = 0;
    int            cycle_count     = 0;
    int            sender_idle_pct = 0;

    sorted_priority_queue #(.DEPTH(STORE_DEPTH)) dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .strobe (strobe),
        .rsp    (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic void predict_results(input spq_pkg::req_t r);
        spq_pkg::rsp_t res;
        int            pos;
        int            shown;
        res      = '0;
        res.last = 1'b1;
        case (r.mode)
            spq_pkg::MODE_INSERT:
            begin
                if (queue_fill >= STORE_DEPTH)
                    res.status = spq_pkg::STATUS_FULL;
                else
                begin
                    pos = 0;
                    while (pos < queue_fill && !(r.value < queue_entries[pos]))
                        pos++;
                    for (int j = queue_fill; j > pos; j--)
                        queue_entries[j] = queue_entries[j-1];
                    queue_entries[pos] = r.value;
                    queue_fill++;
                    res.status = spq_pkg::STATUS_OK;
                end
                res.count = spq_pkg::COUNT_W'(queue_fill);
                expected_rsp.push_back(res);
            end
            spq_pkg::MODE_DELETE:
            begin
                if (queue_fill == 0)
                    res.status = spq_pkg::STATUS_EMPTY;
                else
                begin
                    pos = 0;
                    while (pos < queue_fill && queue_entries[pos] != r.value)
                        pos++;
                    if (pos == queue_fill)
                        res.status = spq_pkg::STATUS_NOTFOUND;
                    else
                    begin
                        for (int j = pos; j + 1 < queue_fill; j++)
                            queue_entries[j] = queue_entries[j+1];
                        queue_fill--;
                        res.status = spq_pkg::STATUS_OK;
                    end
                end
                res.count = spq_pkg::COUNT_W'(queue_fill);
                expected_rsp.push_back(res);
            end
            spq_pkg::MODE_DUMP:
            begin
                res.count = spq_pkg::COUNT_W'(queue_fill);
                if (queue_fill == 0)
                begin
                    res.status = spq_pkg::STATUS_EMPTY;
                    expected_rsp.push_back(res);
                end
                else
                begin
                    shown = (queue_fill > spq_pkg::MAX_OUT) ? spq_pkg::MAX_OUT : queue_fill;
                    for (int i = 0; i < shown; i++)
                    begin
                        res.status = spq_pkg::STATUS_OK;
                        res.data   = queue_entries[i];
                        res.last   = (i == shown - 1);
                        expected_rsp.push_back(res);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    always @(posedge clk)
    begin
        spq_pkg::rsp_t want;
        if (rst_n && strobe)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("unexpected result: status %0d, data %0d, last %0d, count %0d",
                       rsp.status, rsp.data, rsp.last, rsp.count);
                error_count++;
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, rsp.status);
                    error_count++;
                end
                if (rsp.data !== want.data)
                begin
                    $error("data: expected %0d, actual %0d", want.data, rsp.data);
                    error_count++;
                end
                if (rsp.last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, rsp.last);
                    error_count++;
                end
                if (rsp.count !== want.count)
                begin
                    $error("count: expected %0d, actual %0d", want.count, rsp.count);
                    error_count++;
                end
            end
        end
    end

    function automatic spq_pkg::req_t make_request(
        input logic [1:0]                        mode,
        input logic signed [spq_pkg::DATA_W-1:0] value);
        spq_pkg::req_t r;
        r.mode  = mode;
        r.value = value;
        return r;
    endfunction

    // The start line is left high after a request is taken, so that a
    // following request without idle cycles keeps it high throughout.
    task automatic send_request(input spq_pkg::req_t r);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        predict_results(r);
    endtask

    task automatic test_empty_store();
        send_request(make_request(spq_pkg::MODE_DUMP, 32'sd0));
        send_request(make_request(spq_pkg::MODE_DELETE, 32'sd5));
        send_request(make_request(spq_pkg::MODE_UNUSED, VALUE_MIN));
    endtask

    task automatic test_extreme_values();
        send_request(make_request(spq_pkg::MODE_INSERT, VALUE_MAX));
        send_request(make_request(spq_pkg::MODE_INSERT, VALUE_MIN));
        send_request(make_request(spq_pkg::MODE_INSERT, 32'sd0));
        send_request(make_request(spq_pkg::MODE_INSERT, -32'sd1));
        send_request(make_request(spq_pkg::MODE_INSERT, 32'sd0));
        send_request(make_request(spq_pkg::MODE_INSERT, 32'sd1));
        send_request(make_request(spq_pkg::MODE_INSERT, 32'sh55555555));
        send_request(make_request(spq_pkg::MODE_INSERT, 32'shaaaaaaaa));
        send_request(make_request(spq_pkg::MODE_INSERT, 32'sd7));
        send_request(make_request(spq_pkg::MODE_DUMP, 32'sd0));
    endtask

    task automatic test_delete_cases();
        send_request(make_request(spq_pkg::MODE_DELETE, 32'sd12345));
        send_request(make_request(spq_pkg::MODE_DELETE, 32'sd0));
        send_request(make_request(spq_pkg::MODE_DELETE, VALUE_MIN));
        send_request(make_request(spq_pkg::MODE_DUMP, 32'shffffffff));
        send_request(make_request(spq_pkg::MODE_DELETE, VALUE_MAX));
        send_request(make_request(spq_pkg::MODE_UNUSED, VALUE_MAX));
        send_request(make_request(spq_pkg::MODE_DUMP, 32'sd0));
    endtask

    function automatic logic signed [spq_pkg::DATA_W-1:0] pick_value(input logic [1:0] mode);
        int sel;
        sel = $urandom_range(99);
        if (mode == spq_pkg::MODE_DELETE && queue_fill > 0 && sel < 60)
            return queue_entries[$urandom_range(queue_fill - 1)];
        if (sel < 70)
            return int'($urandom_range(16)) - 8;
        if (sel < 80)
            return $urandom_range(1) ? VALUE_MAX : VALUE_MIN;
        return $urandom();
    endfunction

    task automatic test_random_mix(input int requests, input int idle_pct);
        int         done;
        int         pick;
        logic [1:0] mode;
        done            = 0;
        sender_idle_pct = idle_pct;
        while (done < requests)
        begin
            pick = $urandom_range(99);
            if (pick < 42)
                mode = spq_pkg::MODE_INSERT;
            else if (pick < 80)
                mode = spq_pkg::MODE_DELETE;
            else if (pick < 95)
                mode = spq_pkg::MODE_DUMP;
            else
                mode = spq_pkg::MODE_UNUSED;
            send_request(make_request(mode, pick_value(mode)));
            done++;
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_store();
        test_extreme_values();
        test_delete_cases();
        test_random_mix(120, 22);
        test_random_mix(120, 52);
        test_random_mix(120, 0);
        start <= 1'b0;
        while (expected_rsp.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
